// ----- src/pcgr_pkg.sv -----
package pcgr_pkg;

  localparam logic [63:0] LcgMult    = 64'd6364136223846793005;
  localparam logic [63:0] ResetState = 64'h853c49e6748fea9b;
  localparam logic [63:0] ResetInc   = 64'hda3e39cb94b95bdb;

  localparam int unsigned XshShift  = 18;
  localparam int unsigned MixLsb    = 27;
  localparam int unsigned RotLsb    = 59;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ModSteps  = WordW;
  localparam int unsigned ModCntW   = $clog2(ModSteps + 1);

  localparam logic [1:0] ModeDraw    = 2'd0;
  localparam logic [1:0] ModeBounded = 2'd1;
  localparam logic [1:0] ModeReseed  = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  localparam logic [1:0] JobDraw    = 2'd0;
  localparam logic [1:0] JobBounded = 2'd1;
  localparam logic [1:0] JobReseed  = 2'd2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] bound;
    logic [63:0] seed_state;
    logic [63:0] seed_sequence;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bound;
    logic [63:0] seed_state;
    logic [63:0] seed_sequence;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [63:0] state;
    logic [63:0] inc;
  } step_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] state;
  } step_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

  // xorshift-high, random-rotate output of one state
  function automatic logic [31:0] perm(input logic [63:0] old);
    logic [63:0] x;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] dbl;
    x     = (old >> XshShift) ^ old;
    mixed = x[MixLsb +: WordW];
    rot   = old[RotLsb +: 5];
    dbl   = {mixed, mixed} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ----- src/pcgr_stream_if.sv -----
interface pcgr_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/pcgr_lcg_step.sv -----
module pcgr_lcg_step (
  input  logic                 clk,
  input  logic                 rst,
  input  pcgr_pkg::step_req_t  req,
  output pcgr_pkg::step_rsp_t  rsp
);
  import pcgr_pkg::*;

  logic        busy;
  logic        done;
  logic [1:0]  phase;
  logic [63:0] a;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul;

  // low 64 bits of a*M from three 32x32 partial products, one per cycle
  always_comb begin
    mul_a = (phase == 2'd1) ? a[63:32] : a[31:0];
    mul_b = (phase == 2'd2) ? LcgMult[63:32] : LcgMult[31:0];
    mul   = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= req.state;
      acc <= req.inc;
    end else if (busy) begin
      if (phase != 2'd0) acc <= acc + prod;
      if (phase == 2'd0) prod <= mul;
      else               prod <= {mul[31:0], 32'd0};
    end
  end

  assign rsp.done  = done;
  assign rsp.state = acc;

endmodule

// ----- src/pcgr_mod_unit.sv -----
module pcgr_mod_unit (
  input  logic                clk,
  input  logic                rst,
  input  pcgr_pkg::mod_req_t  req,
  output pcgr_pkg::mod_rsp_t  rsp
);
  import pcgr_pkg::*;

  logic               busy;
  logic               done;
  logic [ModCntW-1:0] cnt;
  logic [31:0]        rem;
  logic [31:0]        dvd;
  logic [31:0]        dvs;
  logic [32:0]        trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ModCntW'(ModSteps);
      end else if (busy) begin
        cnt <= cnt - ModCntW'(1);
        if (cnt == ModCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= 32'd0;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, dvs}) rem <= 32'(trial - {1'b0, dvs});
      else                      rem <= trial[31:0];
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ----- src/pcgr_front.sv -----
module pcgr_front (
  input  logic            clk,
  input  logic            rst,
  pcgr_stream_if.sink     req,
  output logic            job_valid,
  input  logic            job_ready,
  output pcgr_pkg::job_t  job
);
  import pcgr_pkg::*;

  req_t             item;
  job_t             cls;
  job_t             q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             fire;
  logic             push;
  logic             pop;

  assign item = req.data;

  // classify: zero bound is a plain draw, unused mode is dropped
  always_comb begin
    cls.bound         = item.bound;
    cls.seed_state    = item.seed_state;
    cls.seed_sequence = item.seed_sequence;
    unique case (item.mode)
      ModeDraw:    cls.kind = JobDraw;
      ModeBounded: cls.kind = (item.bound == 32'd0) ? JobDraw : JobBounded;
      ModeReseed:  cls.kind = JobReseed;
      default:     cls.kind = JobDraw;
    endcase
  end

  assign req.ready = (count != QCntW'(QueueDepth));
  assign fire      = req.valid && req.ready;
  assign push      = fire && (item.mode != ModeUnused);
  assign job_valid = (count != '0);
  assign job       = q[rd_ptr];
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (push && !pop)      count <= count + QCntW'(1);
      else if (pop && !push) count <= count - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

endmodule

// ----- src/pcgr_back.sv -----
module pcgr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  pcgr_pkg::job_t  job,
  pcgr_stream_if.source   rsp
);
  import pcgr_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StThresh = 3'd1;
  localparam logic [2:0] StDraw   = 3'd2;
  localparam logic [2:0] StReduce = 3'd3;
  localparam logic [2:0] StEmit   = 3'd4;
  localparam logic [2:0] StSeed1  = 3'd5;
  localparam logic [2:0] StSeed2  = 3'd6;

  logic [2:0]  state, state_next;
  job_t        cur, cur_next;
  logic [63:0] gen_state, gen_state_next;
  logic [63:0] inc, inc_next;
  logic [31:0] word, word_next;
  logic [31:0] thresh, thresh_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_value, out_value_next;
  logic [63:0] seed_sum;
  step_req_t   step_req;
  step_rsp_t   step_rsp;
  mod_req_t    mod_req;
  mod_rsp_t    mod_rsp;

  pcgr_lcg_step u_step (
    .clk (clk),
    .rst (rst),
    .req (step_req),
    .rsp (step_rsp)
  );

  pcgr_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign seed_sum = step_rsp.state + cur.seed_state;

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    gen_state_next = gen_state;
    inc_next       = inc;
    word_next      = word;
    thresh_next    = thresh;
    out_value_next = out_value;
    out_valid_next = out_valid && !rsp.ready;
    job_ready      = 1'b0;
    step_req       = '{start: 1'b0, state: gen_state, inc: inc};
    mod_req        = '{start: 1'b0, dividend: word, divisor: cur.bound};
    unique case (state)
      StIdle: begin
        job_ready = 1'b1;
        if (job_valid) begin
          cur_next = job;
          case (job.kind)
            JobDraw: begin
              word_next      = perm(gen_state);
              step_req.start = 1'b1;
              state_next     = StDraw;
            end
            JobBounded: begin
              // threshold = (2^32 - bound) mod bound
              mod_req.start    = 1'b1;
              mod_req.dividend = 32'd0 - job.bound;
              mod_req.divisor  = job.bound;
              state_next       = StThresh;
            end
            JobReseed: begin
              inc_next       = {job.seed_sequence[62:0], 1'b1};
              step_req.start = 1'b1;
              step_req.state = 64'd0;
              step_req.inc   = inc_next;
              state_next     = StSeed1;
            end
            default: ;
          endcase
        end
      end
      StThresh: begin
        if (mod_rsp.done) begin
          thresh_next    = mod_rsp.rem;
          word_next      = perm(gen_state);
          step_req.start = 1'b1;
          state_next     = StDraw;
        end
      end
      StDraw: begin
        if (step_rsp.done) begin
          gen_state_next = step_rsp.state;
          if (cur.kind == JobBounded && word < thresh) begin
            // rejected, draw again from the new state
            word_next      = perm(step_rsp.state);
            step_req.start = 1'b1;
            step_req.state = step_rsp.state;
          end else if (cur.kind == JobBounded) begin
            mod_req.start = 1'b1;
            state_next    = StReduce;
          end else begin
            state_next = StEmit;
          end
        end
      end
      StReduce: begin
        if (mod_rsp.done) begin
          word_next  = mod_rsp.rem;
          state_next = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid) begin
          out_valid_next = 1'b1;
          out_value_next = word;
          state_next     = StIdle;
        end
      end
      StSeed1: begin
        if (step_rsp.done) begin
          gen_state_next = seed_sum;
          step_req.start = 1'b1;
          step_req.state = seed_sum;
          state_next     = StSeed2;
        end
      end
      StSeed2: begin
        if (step_rsp.done) begin
          gen_state_next = step_rsp.state;
          state_next     = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      gen_state <= ResetState;
      inc       <= ResetInc;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gen_state <= gen_state_next;
      inc       <= inc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    word      <= word_next;
    thresh    <= thresh_next;
    out_value <= out_value_next;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = rsp_t'{value: out_value};

endmodule

// ----- src/permuted_congruential_random_core.sv -----
// channel  dir  payload                               item
// req      in   mode, bound, seed_state, seed_sequence one request per draw or reseed
// rsp      out  value                                 one result per draw, none per reseed
//
// plain draw: the request passes through the queue, one state step and the emit state; a state step
// is three 32x32 products, then the done pulse, and the emit state loads the output register
// bounded draw: two remainder passes (threshold, then reduction), one state step per word drawn, rejected or not
// reseed: two state steps before the next request can start, no result
// rst is synchronous and restores the default state and increment; mode 3 is dropped at intake
// a 2-deep request queue keeps intake open while a result waits in the output register
module permuted_congruential_random_core (
  input logic           clk,
  input logic           rst,
  pcgr_stream_if.sink   req,
  pcgr_stream_if.source rsp
);
  import pcgr_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;

  pcgr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  pcgr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .rsp       (rsp)
  );

endmodule

// ----- verif/permuted_congruential_random_core_test.sv -----
module permuted_congruential_random_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcgr_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettleCycles = 60;

  logic clk;
  logic rst;

  pcgr_stream_if #(.data_t(req_t)) req_ch ();
  pcgr_stream_if #(.data_t(rsp_t)) rsp_ch ();

  permuted_congruential_random_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // generator copy kept in step with accepted requests
  logic [63:0] lcg_state;
  logic [63:0] lcg_inc;
  logic [31:0] pending_values[$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned cycle_count;
  int unsigned mode_count[4];
  int unsigned rejections;
  int unsigned rsp_hold_cycles;
  int unsigned rsp_gap_left;
  bit          steady;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] folded;
    logic [31:0] word;
    logic [5:0]  amount;
    folded = old ^ (old >> 18);
    word   = folded[58:27];
    amount = {1'b0, old[63:59]};
    return (word >> amount) | (word << (6'd32 - amount));
  endfunction

  function automatic logic [31:0] next_word();
    logic [63:0] old;
    old       = lcg_state;
    lcg_state = old * LcgMult + lcg_inc;
    return xsh_rr(old);
  endfunction

  function automatic logic [31:0] next_below(input logic [31:0] bound);
    logic [31:0] threshold;
    logic [31:0] word;
    if (bound == 32'd0) return next_word();
    threshold = (32'd0 - bound) % bound;
    word = next_word();
    while (word < threshold) begin
      rejections++;
      word = next_word();
    end
    return word % bound;
  endfunction

  task automatic track_request(input req_t r);
    logic [31:0] unused_word;
    mode_count[r.mode]++;
    case (r.mode)
      ModeDraw: begin
        pending_values.push_back(next_word());
      end
      ModeBounded: begin
        pending_values.push_back(next_below(r.bound));
      end
      ModeReseed: begin
        lcg_state   = 64'd0;
        lcg_inc     = {r.seed_sequence[62:0], 1'b1};
        unused_word = next_word();
        lcg_state   = lcg_state + r.seed_state;
        unused_word = next_word();
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1 << $urandom_range(0, 31);
      2: return $urandom_range(1, 16);
      3: return 32'h8000_0000 + $urandom_range(1, 255);
      4: return 32'hffff_ffff - $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) r.mode = ModeDraw;
    else if (roll < 80) r.mode = ModeBounded;
    else if (roll < 93) r.mode = ModeReseed;
    else r.mode = ModeUnused;
    r.bound         = pick_bound();
    r.seed_state    = {$urandom(), $urandom()};
    r.seed_sequence = {$urandom(), $urandom()};
    return r;
  endfunction

  function automatic req_t make_request(input logic [1:0] mode, input logic [31:0] bound,
                                        input logic [63:0] seed, input logic [63:0] seq);
    req_t r;
    r.mode          = mode;
    r.bound         = bound;
    r.seed_state    = seed;
    r.seed_sequence = seq;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    track_request(r);
  endtask

  task automatic lower_request();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic idle_sender();
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      lower_request();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rsp_hold_cycles != 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold_cycles--;
    end else if (steady) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_gap_left != 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_gap_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      if (pending_values.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got value %h", $time,
                 rsp_ch.data.value);
      end else if (rsp_ch.data.value !== pending_values[0]) begin
        mismatches++;
        $display("%0t: value mismatch, expected %h, got %h", $time, pending_values[0],
                 rsp_ch.data.value);
        void'(pending_values.pop_front());
      end else begin
        void'(pending_values.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_values.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    req_t list[$];
    list.push_back(make_request(ModeDraw, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeDraw, 32'hffff_ffff, '1, '1));
    list.push_back(make_request(ModeBounded, 32'd1, 64'd0, 64'd0));
    // zero bound means full range, raw word out
    list.push_back(make_request(ModeBounded, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'hffff_ffff, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'h8000_0001, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'h8000_0001, '1, '1));
    list.push_back(make_request(ModeBounded, 32'h8000_0000, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'd3, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'd7, 64'd0, 64'd0));
    // unused mode with every field set must leave the generator alone
    list.push_back(make_request(ModeUnused, '1, '1, '1));
    list.push_back(make_request(ModeDraw, 32'd5, 64'h1234_5678_9abc_def0, 64'd99));
    list.push_back(make_request(ModeReseed, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeDraw, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'd10, 64'd0, 64'd0));
    list.push_back(make_request(ModeReseed, '1, '1, '1));
    list.push_back(make_request(ModeDraw, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeBounded, 32'h0001_0000, 64'd0, 64'd0));
    list.push_back(make_request(ModeReseed, 32'd0, 64'd42, 64'd54));
    list.push_back(make_request(ModeDraw, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeDraw, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeReseed, 32'd0, 64'h8000_0000_0000_0000,
                                64'h8000_0000_0000_0000));
    list.push_back(make_request(ModeBounded, 32'hffff_fffe, 64'd0, 64'd0));
    list.push_back(make_request(ModeUnused, 32'd0, 64'd0, 64'd0));
    list.push_back(make_request(ModeDraw, 32'd0, 64'd0, 64'd0));
    foreach (list[i]) begin
      send_request(list[i]);
      idle_sender();
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    steady = 1'b1;
    repeat (count) send_request(random_request());
    steady = 1'b0;
  endtask

  task automatic test_result_hold_off();
    rsp_hold_cycles = 400;
    // keep offering draws so the request queue fills and intake stalls
    repeat (12) send_request(make_request(2'($urandom_range(0, 1)), pick_bound(),
                                          {$urandom(), $urandom()}, {$urandom(), $urandom()}));
    idle_sender();
  endtask

  task automatic test_drain_pause(input int unsigned rounds);
    repeat (rounds) begin
      repeat ($urandom_range(1, 6)) begin
        send_request(random_request());
        idle_sender();
      end
      lower_request();
      wait_for_results();
    end
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) begin
      send_request(random_request());
      idle_sender();
    end
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.data     = '0;
    rsp_ch.ready    = 1'b0;
    lcg_state       = ResetState;
    lcg_inc         = ResetInc;
    mismatches      = 0;
    results_checked = 0;
    cycle_count     = 0;
    rejections      = 0;
    rsp_hold_cycles = 0;
    rsp_gap_left    = 0;
    steady          = 1'b0;
    foreach (mode_count[i]) mode_count[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back(150);
    test_result_hold_off();
    test_drain_pause(15);
    test_random_mix(1100);

    lower_request();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d draws, %0d bounded draws (%0d rejected words), %0d reseeds, %0d unused",
             mode_count[ModeDraw], mode_count[ModeBounded], rejections,
             mode_count[ModeReseed], mode_count[ModeUnused]);
    $display("checked %0d results in %0d cycles", results_checked, cycle_count);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
